// ----- hw/rtl/flash_command_serializer_defines.svh -----
// Assertion macros shared by the flash command serializer RTL.
// No dependencies; included by the modules that carry assertions.
`ifndef FLASH_COMMAND_SERIALIZER_DEFINES_SVH
`define FLASH_COMMAND_SERIALIZER_DEFINES_SVH

`ifndef SYNTH

// Clocked assertion that is switched off while reset is asserted.
`define FCS_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

// Clocked assertion that is also checked during reset.
`define FCS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`else

`define FCS_ASSERT(lbl, clk, rst_n, prop, msg)
`define FCS_ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

// ----- hw/rtl/fcs_pkg.sv -----
// Shared types and constants of the flash command serializer.
// No dependencies; used by the sequencer, the datapath and the top level.
`default_nettype none

package fcs_pkg;

    // Field widths of the transfers.
    localparam int ACTION_W = 3;
    localparam int ADDR_W   = 21;
    localparam int BYTE_W   = 8;
    localparam int STEP_W   = 4;

    // Command codes carried in the action field.
    typedef enum logic [ACTION_W-1:0] {
        ACT_CHIP_ID    = 3'd0,
        ACT_CFI_QUERY  = 3'd1,
        ACT_READ_MODE  = 3'd2,
        ACT_PROGRAM    = 3'd3,
        ACT_ERASE      = 3'd4
    } action_t;

    // Position of a byte within the seven-byte bus write frame.
    typedef enum logic [2:0] {
        SLOT_HDR0   = 3'd0,
        SLOT_HDR1   = 3'd1,
        SLOT_HDR2   = 3'd2,
        SLOT_ADDR_H = 3'd3,
        SLOT_ADDR_M = 3'd4,
        SLOT_ADDR_L = 3'd5,
        SLOT_DATA   = 3'd6
    } byte_slot_t;

    // Address source of one bus write.
    typedef enum logic [1:0] {
        ASEL_UNLOCK_A = 2'd0,
        ASEL_UNLOCK_B = 2'd1,
        ASEL_TARGET   = 2'd2
    } addr_sel_t;

    // Data source of one bus write.
    typedef enum logic [3:0] {
        DSEL_UNLOCK_A = 4'd0,
        DSEL_UNLOCK_B = 4'd1,
        DSEL_CHIP_ID  = 4'd2,
        DSEL_CFI      = 4'd3,
        DSEL_RESET    = 4'd4,
        DSEL_PROGRAM  = 4'd5,
        DSEL_ERASE    = 4'd6,
        DSEL_CONFIRM  = 4'd7,
        DSEL_PDATA    = 4'd8
    } data_sel_t;

    // Sequencing op at the end of a bus write.
    typedef enum logic [1:0] {
        OP_NEXT     = 2'd0,
        OP_DISPATCH = 2'd1,
        OP_END      = 2'd2
    } seq_op_t;

    // One microcode control word.
    typedef struct packed {
        seq_op_t   op;
        addr_sel_t asel;
        data_sel_t dsel;
    } ucode_word_t;

    // Control from the sequencer to the datapath.
    typedef struct packed {
        logic       emit;
        logic       last;
        byte_slot_t slot;
        addr_sel_t  asel;
        data_sel_t  dsel;
    } fcs_ctrl_t;

    // Flash command constants.
    localparam logic [ADDR_W-1:0] UNLOCK_ADDR_A = 21'h000AAA;
    localparam logic [ADDR_W-1:0] UNLOCK_ADDR_B = 21'h000555;
    localparam logic [BYTE_W-1:0] UNLOCK_DATA_A = 8'hAA;
    localparam logic [BYTE_W-1:0] UNLOCK_DATA_B = 8'h55;
    localparam logic [BYTE_W-1:0] CMD_CHIP_ID   = 8'h90;
    localparam logic [BYTE_W-1:0] CMD_CFI       = 8'h98;
    localparam logic [BYTE_W-1:0] CMD_RESET     = 8'hF0;
    localparam logic [BYTE_W-1:0] CMD_PROGRAM   = 8'hA0;
    localparam logic [BYTE_W-1:0] CMD_ERASE     = 8'h80;
    localparam logic [BYTE_W-1:0] CMD_CONFIRM   = 8'h30;

    // Bridge frame header bytes.
    localparam logic [BYTE_W-1:0] HDR_BYTE0 = 8'h11;
    localparam logic [BYTE_W-1:0] HDR_BYTE1 = 8'h03;
    localparam logic [BYTE_W-1:0] HDR_BYTE2 = 8'h00;
    localparam logic [2:0]        ADDR_H_TAG = 3'b100;

endpackage

`default_nettype wire

// ----- hw/rtl/fcs_sequencer.sv -----
// Microcoded sequencer: control ROM, step counter and byte slot counter.
// Depends on fcs_pkg and flash_command_serializer_defines.svh.
`default_nettype none

`include "flash_command_serializer_defines.svh"

module fcs_sequencer (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            start,
    input  wire logic [fcs_pkg::ACTION_W-1:0]    action,
    input  wire logic                            advance,
    output logic                                 busy,
    output fcs_pkg::fcs_ctrl_t                   ctrl
);

    // Control program: one word per bus write.
    function automatic fcs_pkg::ucode_word_t ucode_rom(input logic [fcs_pkg::STEP_W-1:0] step);
        fcs_pkg::ucode_word_t w;
        w = '{fcs_pkg::OP_END, fcs_pkg::ASEL_UNLOCK_A, fcs_pkg::DSEL_UNLOCK_A};
        case (step)
            4'd0:  w = '{fcs_pkg::OP_NEXT,     fcs_pkg::ASEL_UNLOCK_A, fcs_pkg::DSEL_UNLOCK_A};
            4'd1:  w = '{fcs_pkg::OP_DISPATCH, fcs_pkg::ASEL_UNLOCK_B, fcs_pkg::DSEL_UNLOCK_B};
            4'd2:  w = '{fcs_pkg::OP_END,      fcs_pkg::ASEL_UNLOCK_A, fcs_pkg::DSEL_CHIP_ID};
            4'd3:  w = '{fcs_pkg::OP_END,      fcs_pkg::ASEL_UNLOCK_A, fcs_pkg::DSEL_CFI};
            4'd4:  w = '{fcs_pkg::OP_END,      fcs_pkg::ASEL_UNLOCK_A, fcs_pkg::DSEL_RESET};
            4'd5:  w = '{fcs_pkg::OP_NEXT,     fcs_pkg::ASEL_UNLOCK_A, fcs_pkg::DSEL_PROGRAM};
            4'd6:  w = '{fcs_pkg::OP_END,      fcs_pkg::ASEL_TARGET,   fcs_pkg::DSEL_PDATA};
            4'd7:  w = '{fcs_pkg::OP_NEXT,     fcs_pkg::ASEL_UNLOCK_A, fcs_pkg::DSEL_ERASE};
            4'd8:  w = '{fcs_pkg::OP_NEXT,     fcs_pkg::ASEL_UNLOCK_A, fcs_pkg::DSEL_UNLOCK_A};
            4'd9:  w = '{fcs_pkg::OP_NEXT,     fcs_pkg::ASEL_UNLOCK_B, fcs_pkg::DSEL_UNLOCK_B};
            4'd10: w = '{fcs_pkg::OP_END,      fcs_pkg::ASEL_TARGET,   fcs_pkg::DSEL_CONFIRM};
            default: w = '{fcs_pkg::OP_END,    fcs_pkg::ASEL_UNLOCK_A, fcs_pkg::DSEL_UNLOCK_A};
        endcase
        return w;
    endfunction

    // Entry step of each command after the shared unlock pair.
    function automatic logic [fcs_pkg::STEP_W-1:0] entry_step(input logic [fcs_pkg::ACTION_W-1:0] act);
        logic [fcs_pkg::STEP_W-1:0] s;
        s = 4'd2;
        case (act)
            fcs_pkg::ACT_CHIP_ID:   s = 4'd2;
            fcs_pkg::ACT_CFI_QUERY: s = 4'd3;
            fcs_pkg::ACT_READ_MODE: s = 4'd4;
            fcs_pkg::ACT_PROGRAM:   s = 4'd5;
            fcs_pkg::ACT_ERASE:     s = 4'd7;
            default:                s = 4'd2;
        endcase
        return s;
    endfunction

    logic                          busy_reg, busy_next;
    logic [fcs_pkg::STEP_W-1:0]    step_reg, step_next;
    fcs_pkg::byte_slot_t           slot_reg, slot_next;
    logic [fcs_pkg::ACTION_W-1:0]  action_reg, action_next;
    fcs_pkg::ucode_word_t          uword;
    logic                          cmd_known;
    logic                          emit;

    assign uword     = ucode_rom(step_reg);
    assign cmd_known = (action == fcs_pkg::ACT_CHIP_ID) || (action == fcs_pkg::ACT_CFI_QUERY) ||
                       (action == fcs_pkg::ACT_READ_MODE) || (action == fcs_pkg::ACT_PROGRAM) ||
                       (action == fcs_pkg::ACT_ERASE);
    assign emit      = busy_reg && advance;

    // Step and slot sequencing; unknown commands are dropped at the start.
    always_comb begin
        busy_next   = busy_reg;
        step_next   = step_reg;
        slot_next   = slot_reg;
        action_next = action_reg;
        if (start && !busy_reg) begin
            if (cmd_known) begin
                busy_next   = 1'b1;
                step_next   = '0;
                slot_next   = fcs_pkg::SLOT_HDR0;
                action_next = action;
            end
        end else if (emit) begin
            if (slot_reg == fcs_pkg::SLOT_DATA) begin
                slot_next = fcs_pkg::SLOT_HDR0;
                case (uword.op)
                    fcs_pkg::OP_NEXT:     step_next = step_reg + 4'd1;
                    fcs_pkg::OP_DISPATCH: step_next = entry_step(action_reg);
                    fcs_pkg::OP_END:      busy_next = 1'b0;
                    default:              busy_next = 1'b0;
                endcase
            end else begin
                slot_next = fcs_pkg::byte_slot_t'(slot_reg + 3'd1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg   <= 1'b0;
            step_reg   <= '0;
            slot_reg   <= fcs_pkg::SLOT_HDR0;
            action_reg <= '0;
        end else begin
            busy_reg   <= busy_next;
            step_reg   <= step_next;
            slot_reg   <= slot_next;
            action_reg <= action_next;
        end
    end

    // Control toward the datapath.
    assign busy      = busy_reg;
    assign ctrl.emit = emit;
    assign ctrl.last = (slot_reg == fcs_pkg::SLOT_DATA) && (uword.op == fcs_pkg::OP_END);
    assign ctrl.slot = slot_reg;
    assign ctrl.asel = uword.asel;
    assign ctrl.dsel = uword.dsel;

    // The final byte of a command frees the sequencer.
    `FCS_ASSERT(a_last_ends, aclk, aresetn, emit && ctrl.last |=> !busy_reg, "busy after last byte")
    // A byte is only marked last in the data slot of a bus write.
    `FCS_ASSERT(a_last_slot, aclk, aresetn, ctrl.last |-> slot_reg == fcs_pkg::SLOT_DATA, "last outside data slot")
    // The step counter stays inside the control program.
    `FCS_ASSERT(a_step_range, aclk, aresetn, busy_reg |-> step_reg <= 4'd10, "step out of program")
    // Without a byte going out the position in the program holds.
    `FCS_ASSERT(a_hold, aclk, aresetn, busy_reg && !advance |=> $stable(step_reg) && $stable(slot_reg), "step moved while stalled")

endmodule

`default_nettype wire

// ----- hw/rtl/fcs_datapath.sv -----
// Datapath: operand registers, byte formatter and output register.
// Depends on fcs_pkg and flash_command_serializer_defines.svh.
`default_nettype none

`include "flash_command_serializer_defines.svh"

module fcs_datapath #(
    parameter int ADDR_BITS = 21
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          load,
    input  wire logic [fcs_pkg::ADDR_W-1:0]    target_address,
    input  wire logic [fcs_pkg::BYTE_W-1:0]    program_data,
    input  wire logic                          reverse_data,
    input  wire fcs_pkg::fcs_ctrl_t            ctrl,
    output logic                               out_free,
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    output logic [fcs_pkg::BYTE_W-1:0]         m_tdata,
    output logic                               m_tlast
);

    localparam logic [fcs_pkg::ADDR_W-1:0] ADDR_MASK =
        fcs_pkg::ADDR_W'((64'd1 << ADDR_BITS) - 64'd1);

    // Bit-order reversal of one byte.
    function automatic logic [fcs_pkg::BYTE_W-1:0] rev8(input logic [fcs_pkg::BYTE_W-1:0] v);
        logic [fcs_pkg::BYTE_W-1:0] r;
        for (int i = 0; i < fcs_pkg::BYTE_W; i++) begin
            r[i] = v[fcs_pkg::BYTE_W-1-i];
        end
        return r;
    endfunction

    logic [fcs_pkg::ADDR_W-1:0] target_reg;
    logic [fcs_pkg::BYTE_W-1:0] pdata_reg;
    logic                       m_tvalid_reg, m_tvalid_next;
    logic [fcs_pkg::BYTE_W-1:0] m_tdata_reg;
    logic                       m_tlast_reg;
    logic [fcs_pkg::ADDR_W-1:0] addr;
    logic [fcs_pkg::BYTE_W-1:0] data;
    logic [fcs_pkg::BYTE_W-1:0] byte_val;

    // Operands captured with the command transfer.
    always_ff @(posedge aclk) begin
        if (load) begin
            target_reg <= target_address & ADDR_MASK;
            pdata_reg  <= program_data;
        end
    end

    // Address and data of the current bus write.
    always_comb begin
        case (ctrl.asel)
            fcs_pkg::ASEL_UNLOCK_A: addr = fcs_pkg::UNLOCK_ADDR_A;
            fcs_pkg::ASEL_UNLOCK_B: addr = fcs_pkg::UNLOCK_ADDR_B;
            fcs_pkg::ASEL_TARGET:   addr = target_reg;
            default:                addr = fcs_pkg::UNLOCK_ADDR_A;
        endcase
        case (ctrl.dsel)
            fcs_pkg::DSEL_UNLOCK_A: data = fcs_pkg::UNLOCK_DATA_A;
            fcs_pkg::DSEL_UNLOCK_B: data = fcs_pkg::UNLOCK_DATA_B;
            fcs_pkg::DSEL_CHIP_ID:  data = fcs_pkg::CMD_CHIP_ID;
            fcs_pkg::DSEL_CFI:      data = fcs_pkg::CMD_CFI;
            fcs_pkg::DSEL_RESET:    data = fcs_pkg::CMD_RESET;
            fcs_pkg::DSEL_PROGRAM:  data = fcs_pkg::CMD_PROGRAM;
            fcs_pkg::DSEL_ERASE:    data = fcs_pkg::CMD_ERASE;
            fcs_pkg::DSEL_CONFIRM:  data = fcs_pkg::CMD_CONFIRM;
            fcs_pkg::DSEL_PDATA:    data = reverse_data ? rev8(pdata_reg) : pdata_reg;
            default:                data = fcs_pkg::UNLOCK_DATA_A;
        endcase
    end

    // Byte of the bridge frame at the current slot.
    always_comb begin
        case (ctrl.slot)
            fcs_pkg::SLOT_HDR0:   byte_val = fcs_pkg::HDR_BYTE0;
            fcs_pkg::SLOT_HDR1:   byte_val = fcs_pkg::HDR_BYTE1;
            fcs_pkg::SLOT_HDR2:   byte_val = fcs_pkg::HDR_BYTE2;
            fcs_pkg::SLOT_ADDR_H: byte_val = {fcs_pkg::ADDR_H_TAG, addr[20:16]};
            fcs_pkg::SLOT_ADDR_M: byte_val = addr[15:8];
            fcs_pkg::SLOT_ADDR_L: byte_val = addr[7:0];
            fcs_pkg::SLOT_DATA:   byte_val = data;
            default:              byte_val = data;
        endcase
    end

    // Output register: refilled whenever it is empty or being drained.
    assign out_free = !m_tvalid_reg || m_tready;

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        if (ctrl.emit) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.emit) begin
            m_tdata_reg <= byte_val;
            m_tlast_reg <= ctrl.last;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

    // A byte is only produced into a free output register.
    `FCS_ASSERT(a_emit_free, aclk, aresetn, ctrl.emit |-> out_free, "byte produced into full register")
    // A produced byte is offered in the next cycle.
    `FCS_ASSERT(a_emit_valid, aclk, aresetn, ctrl.emit |=> m_tvalid_reg, "produced byte not offered")
    // Operands are not reloaded while a command is being sent.
    `FCS_ASSERT(a_load_idle, aclk, aresetn, load |-> !ctrl.emit, "operands reloaded mid command")

endmodule

`default_nettype wire

// ----- hw/rtl/flash_command_serializer.sv -----
// Top level of the flash command serializer.
// Depends on fcs_pkg, fcs_sequencer and fcs_datapath.
`default_nettype none

// Takes one flash command per input transfer and sends it to a serial bridge as a byte
// stream, one byte per output transfer, with m_tlast on the final byte. Every flash bus
// write goes out as a seven-byte frame; a command is 3 writes (21 bytes) for chip-ID entry,
// CFI query entry and read mode, 4 writes (28 bytes) for program byte and 6 writes
// (42 bytes) for block erase. An 11-word control ROM stepped by a write counter and a
// byte-slot counter produces one byte per clock into a single output register while the
// sink does not stall it; while the sink stalls a full output register, the sequencer
// holds its place in the program.
// The next command is taken in the cycle after its predecessor's last byte enters the
// output register. Actions 5 to 7 are accepted and dropped without output. The register
// written through cfg_we selects bit-reversal of the program data byte (reset: on).

module flash_command_serializer #(
    parameter int ADDR_BITS = 21
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // Configuration write port.
    input  wire logic        cfg_we,
    input  wire logic        cfg_wdata,     // reverse_program_data
    // Command input channel.
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,       // action[2:0], target_address[23:3], program_data[31:24]
    // Byte output channel.
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [7:0]       m_tdata,       // out_byte[7:0]
    output logic             m_tlast
);

    logic               reverse_reg;
    logic               busy;
    logic               accept;
    logic               out_free;
    fcs_pkg::fcs_ctrl_t ctrl;

    // Configuration register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            reverse_reg <= 1'b1;
        end else if (cfg_we) begin
            reverse_reg <= cfg_wdata;
        end
    end

    // A command transfer is taken whenever no command is in progress.
    assign s_tready = !busy;
    assign accept   = s_tvalid && s_tready;

    fcs_sequencer u_seq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (accept),
        .action  (s_tdata[2:0]),
        .advance (out_free),
        .busy    (busy),
        .ctrl    (ctrl)
    );

    fcs_datapath #(
        .ADDR_BITS (ADDR_BITS)
    ) u_dp (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .load           (accept),
        .target_address (s_tdata[23:3]),
        .program_data   (s_tdata[31:24]),
        .reverse_data   (reverse_reg),
        .ctrl           (ctrl),
        .out_free       (out_free),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .m_tlast        (m_tlast)
    );

endmodule

`default_nettype wire

// ----- tb/flash_command_serializer_tb.sv -----
// Self-checking testbench for flash_command_serializer: directed table, then random commands.
// Depends on fcs_pkg and the flash_command_serializer RTL; expected bytes come from a local
// predictor.
`timescale 1ns / 100ps

module flash_command_serializer_tb;

    localparam int ADDR_BITS       = 21;
    localparam logic [31:0] ADDR_MASK = (32'd1 << ADDR_BITS) - 32'd1;
    localparam int DRAIN_CYCLES    = 64;
    localparam int QUIET_LIMIT     = 2000;
    localparam int REPORT_LIMIT    = 10;
    localparam int PHASE_COMMANDS  = 100;
    localparam int NUM_ROWS        = 22;

    // Codes above block erase are dropped by the block.
    localparam logic [fcs_pkg::ACTION_W-1:0] ACT_FIRST_UNUSED = fcs_pkg::ACT_ERASE + 3'd1;
    localparam logic [fcs_pkg::ACTION_W-1:0] ACT_MID_UNUSED   = ACT_FIRST_UNUSED + 3'd1;
    localparam logic [fcs_pkg::ACTION_W-1:0] ACT_LAST_UNUSED  = '1;

    // One expected byte of a command stream.
    typedef struct packed {
        logic [fcs_pkg::BYTE_W-1:0] value;
        logic                       last;
    } flash_byte_t;

    // One row of the directed table: a register write or a command.
    typedef struct packed {
        logic                         is_cfg;
        logic                         cfg_value;
        logic [fcs_pkg::ACTION_W-1:0] action;
        logic [fcs_pkg::ADDR_W-1:0]   addr;
        logic [fcs_pkg::BYTE_W-1:0]   data;
        logic                         fixed;
        logic [5:0]                   fixed_len;
        logic [fcs_pkg::BYTE_W-1:0]   fixed_tail;
    } cmd_row_t;

    logic              aclk;
    logic              aresetn;
    logic              cfg_we;
    logic              cfg_wdata;
    logic              s_tvalid;
    logic              s_tready;
    logic [31:0]       s_tdata;    // action[2:0], target_address[23:3], program_data[31:24]
    logic              m_tvalid;
    logic              m_tready;
    logic [7:0]        m_tdata;    // out_byte[7:0]
    logic              m_tlast;

    flash_byte_t       pending_bytes[$];
    logic              reverse_data;
    int                mismatches;
    int                quiet_cycles;
    int                bytes_checked;
    int                commands_sent;
    int                dropped_sent;
    int                cfg_writes;
    bit                src_calm;
    bit                snk_calm;

    cmd_row_t directed_rows [0:NUM_ROWS-1] = '{
        '{1'b0, 1'b0, fcs_pkg::ACT_CHIP_ID,   21'h000000, 8'h00, 1'b1, 6'd21,
          fcs_pkg::CMD_CHIP_ID},
        '{1'b0, 1'b0, fcs_pkg::ACT_CFI_QUERY, 21'h1FFFFF, 8'hFF, 1'b1, 6'd21, fcs_pkg::CMD_CFI},
        '{1'b0, 1'b0, fcs_pkg::ACT_READ_MODE, 21'h0A5A5A, 8'h3C, 1'b1, 6'd21,
          fcs_pkg::CMD_RESET},
        '{1'b0, 1'b0, fcs_pkg::ACT_PROGRAM,   21'h000000, 8'h01, 1'b1, 6'd28, 8'h80},
        '{1'b0, 1'b0, fcs_pkg::ACT_PROGRAM,   21'h1FFFFF, 8'hFF, 1'b1, 6'd28, 8'hFF},
        '{1'b0, 1'b0, fcs_pkg::ACT_PROGRAM,   21'h0F0F0F, 8'h0F, 1'b1, 6'd28, 8'hF0},
        '{1'b0, 1'b0, fcs_pkg::ACT_ERASE,     21'h000000, 8'h00, 1'b1, 6'd42,
          fcs_pkg::CMD_CONFIRM},
        '{1'b0, 1'b0, fcs_pkg::ACT_ERASE,     21'h1FFFFF, 8'hFF, 1'b1, 6'd42,
          fcs_pkg::CMD_CONFIRM},
        '{1'b0, 1'b0, ACT_FIRST_UNUSED,       21'h000000, 8'h00, 1'b1, 6'd0,  8'h00},
        '{1'b0, 1'b0, ACT_LAST_UNUSED,        21'h1FFFFF, 8'hFF, 1'b1, 6'd0,  8'h00},
        '{1'b0, 1'b0, fcs_pkg::ACT_PROGRAM,   21'h155555, 8'h5A, 1'b0, 6'd0,  8'h00},
        '{1'b0, 1'b0, fcs_pkg::ACT_ERASE,     21'h010000, 8'h00, 1'b0, 6'd0,  8'h00},
        '{1'b0, 1'b0, ACT_MID_UNUSED,         21'h123456, 8'hA5, 1'b1, 6'd0,  8'h00},
        '{1'b0, 1'b0, fcs_pkg::ACT_CHIP_ID,   21'h1FFFFF, 8'hFF, 1'b1, 6'd21,
          fcs_pkg::CMD_CHIP_ID},
        '{1'b0, 1'b0, fcs_pkg::ACT_PROGRAM,   21'h000AAA, 8'h80, 1'b1, 6'd28, 8'h01},
        '{1'b1, 1'b0, fcs_pkg::ACT_CHIP_ID,   21'h000000, 8'h00, 1'b0, 6'd0,  8'h00},
        '{1'b0, 1'b0, fcs_pkg::ACT_PROGRAM,   21'h000000, 8'h01, 1'b1, 6'd28, 8'h01},
        '{1'b0, 1'b0, fcs_pkg::ACT_PROGRAM,   21'h1FFFFF, 8'hF0, 1'b1, 6'd28, 8'hF0},
        '{1'b0, 1'b0, fcs_pkg::ACT_ERASE,     21'h0AAAAA, 8'h55, 1'b0, 6'd0,  8'h00},
        '{1'b0, 1'b0, fcs_pkg::ACT_READ_MODE, 21'h000000, 8'h00, 1'b0, 6'd0,  8'h00},
        '{1'b1, 1'b1, fcs_pkg::ACT_CHIP_ID,   21'h000000, 8'h00, 1'b0, 6'd0,  8'h00},
        '{1'b0, 1'b0, fcs_pkg::ACT_PROGRAM,   21'h100000, 8'hC3, 1'b0, 6'd0,  8'h00}
    };

    flash_command_serializer #(
        .ADDR_BITS (ADDR_BITS)
    ) i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    // Free-running clock.
    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Counts mismatches and reports only the first few in detail.
    function automatic void record_mismatch(string what, int want, int got);
        mismatches++;
        if (mismatches <= REPORT_LIMIT) begin
            $display("Mismatch on %s at %0t: expected 0x%0h, got 0x%0h", what, $realtime,
                     want, got);
        end
    endfunction

    function automatic void push_stream_byte(logic [fcs_pkg::BYTE_W-1:0] b);
        pending_bytes.push_back(flash_byte_t'{value: b, last: 1'b0});
    endfunction

    // One flash bus write is a bridge header, three address bytes and the data byte.
    function automatic void push_bus_write(logic [fcs_pkg::ADDR_W-1:0] addr,
                                           logic [fcs_pkg::BYTE_W-1:0] data);
        push_stream_byte(fcs_pkg::HDR_BYTE0);
        push_stream_byte(fcs_pkg::HDR_BYTE1);
        push_stream_byte(fcs_pkg::HDR_BYTE2);
        push_stream_byte({fcs_pkg::ADDR_H_TAG, addr[20:16]});
        push_stream_byte(addr[15:8]);
        push_stream_byte(addr[7:0]);
        push_stream_byte(data);
    endfunction

    function automatic void push_unlock_pair();
        push_bus_write(fcs_pkg::UNLOCK_ADDR_A, fcs_pkg::UNLOCK_DATA_A);
        push_bus_write(fcs_pkg::UNLOCK_ADDR_B, fcs_pkg::UNLOCK_DATA_B);
    endfunction

    // Appends the byte stream of one command and returns how many bytes it holds.
    function automatic int predict_command(logic [fcs_pkg::ACTION_W-1:0] act,
                                           logic [fcs_pkg::ADDR_W-1:0] addr,
                                           logic [fcs_pkg::BYTE_W-1:0] data);
        logic [fcs_pkg::ADDR_W-1:0] target;
        logic [fcs_pkg::BYTE_W-1:0] sent_data;
        int                         first;
        target = addr & ADDR_MASK[fcs_pkg::ADDR_W-1:0];
        if (reverse_data) begin
            sent_data = {<<{data}};
        end else begin
            sent_data = data;
        end
        first = pending_bytes.size();
        if (act > fcs_pkg::ACT_ERASE) begin
            return 0;
        end
        push_unlock_pair();
        case (act)
            fcs_pkg::ACT_CHIP_ID: begin
                push_bus_write(fcs_pkg::UNLOCK_ADDR_A, fcs_pkg::CMD_CHIP_ID);
            end
            fcs_pkg::ACT_CFI_QUERY: begin
                push_bus_write(fcs_pkg::UNLOCK_ADDR_A, fcs_pkg::CMD_CFI);
            end
            fcs_pkg::ACT_READ_MODE: begin
                push_bus_write(fcs_pkg::UNLOCK_ADDR_A, fcs_pkg::CMD_RESET);
            end
            fcs_pkg::ACT_PROGRAM: begin
                push_bus_write(fcs_pkg::UNLOCK_ADDR_A, fcs_pkg::CMD_PROGRAM);
                push_bus_write(target, sent_data);
            end
            default: begin
                push_bus_write(fcs_pkg::UNLOCK_ADDR_A, fcs_pkg::CMD_ERASE);
                push_unlock_pair();
                push_bus_write(target, fcs_pkg::CMD_CONFIRM);
            end
        endcase
        pending_bytes[pending_bytes.size()-1].last = 1'b1;
        return pending_bytes.size() - first;
    endfunction

    // Offers one command after a random gap and records its bytes once it is taken.
    task automatic send_cmd(input logic [fcs_pkg::ACTION_W-1:0] act,
                            input logic [fcs_pkg::ADDR_W-1:0] addr,
                            input logic [fcs_pkg::BYTE_W-1:0] data, output int produced);
        int pause;
        if ($urandom_range(0, 39) == 0) begin
            src_calm = !src_calm;
        end
        pause = src_calm ? 0 : $urandom_range(0, 16);
        if (pause > 0) begin
            s_tvalid <= 1'b0;
            repeat (pause) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {data, addr, act};
        do @(posedge aclk); while (!s_tready);
        produced = predict_command(act, addr, data);
        if (produced > 0) begin
            commands_sent++;
        end else begin
            dropped_sent++;
        end
    endtask

    // Register writes happen only once the block has drained.
    task automatic set_reverse(input logic value);
        s_tvalid <= 1'b0;
        while (pending_bytes.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_we       <= 1'b0;
        reverse_data  = value;
        cfg_writes++;
    endtask

    // Stimulus: reset, the directed table, then random phases under both register settings.
    initial begin
        int                           produced;
        int                           phase_cmds;
        logic [31:0]                  rnd;
        logic [fcs_pkg::ACTION_W-1:0] act;
        logic [fcs_pkg::ADDR_W-1:0]   addr;
        logic [fcs_pkg::BYTE_W-1:0]   pdata;
        cmd_row_t                     row;
        aresetn       = 1'b0;
        cfg_we        = 1'b0;
        cfg_wdata     = 1'b0;
        s_tvalid      = 1'b0;
        s_tdata       = '0;
        reverse_data  = 1'b1;
        mismatches    = 0;
        bytes_checked = 0;
        commands_sent = 0;
        dropped_sent  = 0;
        cfg_writes    = 0;
        src_calm      = 1'b0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed rows; where a row has typed-in values its length is checked and its tail replaces the prediction.
        for (int i = 0; i < NUM_ROWS; i++) begin
            row = directed_rows[i];
            if (row.is_cfg) begin
                set_reverse(row.cfg_value);
            end else begin
                send_cmd(row.action, row.addr, row.data, produced);
                if (row.fixed) begin
                    if (produced != row.fixed_len) begin
                        record_mismatch("stream length", row.fixed_len, produced);
                    end
                    if (produced > 0) begin
                        pending_bytes[pending_bytes.size()-1].value = row.fixed_tail;
                    end
                end
            end
        end

        // Random phases alternate the bit-reversal setting.
        for (int phase = 0; phase < 4; phase++) begin
            set_reverse(phase[0]);
            phase_cmds = 0;
            while (phase_cmds < PHASE_COMMANDS) begin
                if ($urandom_range(0, 9) == 0) begin
                    rnd = $urandom_range(ACT_FIRST_UNUSED, ACT_LAST_UNUSED);
                end else begin
                    rnd = $urandom_range(fcs_pkg::ACT_CHIP_ID, fcs_pkg::ACT_ERASE);
                end
                act = rnd[fcs_pkg::ACTION_W-1:0];
                case ($urandom_range(0, 7))
                    0:       addr = '0;
                    1:       addr = '1;
                    2:       addr = fcs_pkg::UNLOCK_ADDR_A;
                    default: begin
                        rnd  = $urandom;
                        addr = rnd[fcs_pkg::ADDR_W-1:0];
                    end
                endcase
                rnd   = $urandom;
                pdata = rnd[fcs_pkg::BYTE_W-1:0];
                send_cmd(act, addr, pdata, produced);
                phase_cmds++;
            end
        end

        // Drain, then let the block settle before the verdict.
        s_tvalid <= 1'b0;
        while (pending_bytes.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        $display("Run covered %0d commands and %0d dropped codes, %0d stream bytes checked.",
                 commands_sent, dropped_sent, bytes_checked);
        $display("Bit-reversal register written %0d times; %0d mismatches.", cfg_writes,
                 mismatches);
        if (mismatches == 0 && pending_bytes.size() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

    // Output sink with random stalls between transfers.
    initial begin
        int pause;
        m_tready = 1'b0;
        snk_calm = 1'b0;
        while (!aresetn) @(posedge aclk);
        forever begin
            if ($urandom_range(0, 39) == 0) begin
                snk_calm = !snk_calm;
            end
            pause = snk_calm ? 0 : $urandom_range(0, 16);
            if (pause > 0) begin
                m_tready <= 1'b0;
                repeat (pause) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
        end
    end

    // Every output transfer is checked against the oldest expected byte.
    always @(posedge aclk) begin
        flash_byte_t want;
        if (aresetn && m_tvalid && m_tready) begin
            bytes_checked++;
            if (pending_bytes.size() == 0) begin
                record_mismatch("unexpected byte", 0, m_tdata);
            end else begin
                want = pending_bytes.pop_front();
                if (m_tdata !== want.value) begin
                    record_mismatch("out_byte", want.value, m_tdata);
                end
                if (m_tlast !== want.last) begin
                    record_mismatch("last_byte", want.last, m_tlast);
                end
            end
        end
    end

    // Watchdog on cycles without any transfer or register write.
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("Timeout: no transfer for %0d cycles", QUIET_LIMIT);
            $display("FAILED: results differ");
            $finish;
        end
    end

endmodule

// ----- flash_command_serializer.f -----
+incdir+hw/rtl
hw/rtl/fcs_pkg.sv
hw/rtl/fcs_sequencer.sv
hw/rtl/fcs_datapath.sv
hw/rtl/flash_command_serializer.sv
tb/flash_command_serializer_tb.sv
